FILE: rtl/core/jpeg_frame_header_scanner_assert.svh
// ----------------------------------------------------------------------------
// JPEG frame header scanner assertion macros
// Concurrent check macros shared by the scanner RTL; empty when ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef JPEG_FRAME_HEADER_SCANNER_ASSERT_SVH
`define JPEG_FRAME_HEADER_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define JFHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jfhs: same-cycle check failed");
// Next-cycle implication
`define JFHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jfhs: next-cycle check failed");
`else
`define JFHS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JFHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/jfhs_pkg.sv
// ----------------------------------------------------------------------------
// JPEG frame header scanner package
// Parse phase codes, marker byte values and header field defaults.
// ----------------------------------------------------------------------------
package jfhs_pkg;

    // Parse phase codes
    localparam logic [2:0] PH_SOI0   = 3'd0;
    localparam logic [2:0] PH_SOI1   = 3'd1;
    localparam logic [2:0] PH_SCAN   = 3'd2;
    localparam logic [2:0] PH_MARKER = 3'd3;
    localparam logic [2:0] PH_LENHI  = 3'd4;
    localparam logic [2:0] PH_LENLO  = 3'd5;
    localparam logic [2:0] PH_FRAME  = 3'd6;
    localparam logic [2:0] PH_DONE   = 3'd7;

    // Marker bytes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;

    // Field defaults when no frame header is captured
    localparam logic [7:0] DEF_PRECISION  = 8'd8;
    localparam logic [7:0] DEF_COMPONENTS = 8'd3;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_dim;

endpackage

FILE: rtl/core/jpeg_frame_header_scanner.sv
// ----------------------------------------------------------------------------
// JPEG frame header scanner
// Walks a JPEG byte stream and reports the frame header fields once.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one stream byte per item
//   plus a first-byte flag that restarts parsing of a new image.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the stream length; it
//   is always ready and should be written while the block is idle.
//   Output channel (o_out_valid / i_out_ready) carries one result per image:
//   status, width, height, precision and component count.
//   A result is registered in the cycle after the byte that decides it.
//   Throughput: one byte per cycle unless a held result stalls the input;
//   marker compare, segment length add and the index counter update are all
//   combinational between the input and the parse and result registers.
//   When the receiver stalls with a result held, o_in_ready drops until the
//   result is taken; bytes that cause no result still pass when it is empty.
//   Reset (synchronous, active low) clears the stream length to zero, the
//   parse state to the start-of-image check and drops any held result.
// ----------------------------------------------------------------------------
`include "jpeg_frame_header_scanner_assert.svh"

module jpeg_frame_header_scanner #(
    parameter int INDEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_stream_length,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jfhs_pkg::t_byte     i_data_byte,
    input  logic                i_first_byte,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_header_status,
    output jfhs_pkg::t_dim      o_image_width,
    output jfhs_pkg::t_dim      o_image_height,
    output jfhs_pkg::t_byte     o_sample_precision,
    output jfhs_pkg::t_byte     o_component_count
);
    import jfhs_pkg::*;

    // marker position plus a full 16-bit segment length must fit
    localparam int NP_W  = INDEX_BITS + 2;
    localparam int CMP_W = (INDEX_BITS + 2 > 33) ? INDEX_BITS + 2 : 33;

    // Parse state
    logic [31:0]            r_stream_length;
    logic [INDEX_BITS-1:0]  r_index,   n_index;
    logic [NP_W-1:0]        r_np,      n_np;
    logic [2:0]             r_phase,   n_phase;
    logic [INDEX_BITS-1:0]  r_mstart,  n_mstart;
    t_byte                  r_len_hi,  n_len_hi;
    t_dim                   r_width,   n_width;
    t_dim                   r_height,  n_height;
    t_byte                  r_prec,    n_prec;
    t_byte                  r_comp,    n_comp;
    logic                   r_finished, n_finished;

    // Result register
    logic                   r_out_valid;
    logic                   r_out_status;
    t_dim                   r_out_width;
    t_dim                   r_out_height;
    t_byte                  r_out_prec;
    t_byte                  r_out_comp;

    logic                   in_accept;
    logic                   done;
    logic [CMP_W-1:0]       sz_ext;
    logic [NP_W-1:0]        seg_next;
    logic [INDEX_BITS-1:0]  frame_off;
    logic                   out_dims_zero;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign sz_ext      = CMP_W'(r_stream_length);

    // Next parse state for the byte at the input
    always_comb begin
        n_index    = r_index;
        n_np       = r_np;
        n_phase    = r_phase;
        n_mstart   = r_mstart;
        n_len_hi   = r_len_hi;
        n_width    = r_width;
        n_height   = r_height;
        n_prec     = r_prec;
        n_comp     = r_comp;
        n_finished = r_finished;
        done       = 1'b0;
        seg_next   = '0;
        frame_off  = '0;

        // restart on the first byte of a new image
        if (i_first_byte) begin
            n_index    = '0;
            n_np       = NP_W'(2);
            n_phase    = PH_SOI0;
            n_mstart   = '0;
            n_len_hi   = '0;
            n_width    = '0;
            n_height   = '0;
            n_prec     = DEF_PRECISION;
            n_comp     = DEF_COMPONENTS;
            n_finished = 1'b0;
        end

        if (!n_finished) begin
            unique case (n_phase)
                PH_SOI0: begin
                    if (r_stream_length < 32'd2 || i_data_byte != MK_PREFIX) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PH_SOI1;
                    end
                end
                PH_SOI1: begin
                    if (i_data_byte != MK_SOI) begin
                        done = 1'b1;
                    end else begin
                        n_np = NP_W'(2);
                        if (CMP_W'(6) >= sz_ext) begin
                            done = 1'b1;
                        end else begin
                            n_phase = PH_SCAN;
                        end
                    end
                end
                PH_SCAN: begin
                    if (NP_W'(n_index) == n_np) begin
                        if (i_data_byte != MK_PREFIX) begin
                            n_np = NP_W'(n_index) + NP_W'(1);
                            if (CMP_W'(n_np) + CMP_W'(4) >= sz_ext) begin
                                done = 1'b1;
                            end
                        end else begin
                            n_mstart = n_index;
                            n_phase  = PH_MARKER;
                        end
                    end
                end
                PH_MARKER: begin
                    case (i_data_byte) inside
                        MK_SOF0, MK_SOF1, MK_SOF2: begin
                            if (CMP_W'(n_mstart) + CMP_W'(9) < sz_ext) begin
                                n_phase = PH_FRAME;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        MK_EOI, MK_SOS: begin
                            done = 1'b1;
                        end
                        default: begin
                            n_phase = PH_LENHI;
                        end
                    endcase
                end
                PH_LENHI: begin
                    n_len_hi = i_data_byte;
                    n_phase  = PH_LENLO;
                end
                PH_LENLO: begin
                    // skip the segment; never move the scan backwards
                    seg_next = NP_W'(n_mstart) + NP_W'(2) + NP_W'({n_len_hi, i_data_byte});
                    if (seg_next <= NP_W'(n_index)) begin
                        n_np = NP_W'(n_index) + NP_W'(1);
                    end else begin
                        n_np = seg_next;
                    end
                    if (CMP_W'(n_np) + CMP_W'(4) >= sz_ext) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PH_SCAN;
                    end
                end
                PH_FRAME: begin
                    // capture frame header fields by offset from the marker
                    frame_off = n_index - n_mstart;
                    if (frame_off == INDEX_BITS'(4)) begin
                        n_prec = i_data_byte;
                    end else if (frame_off == INDEX_BITS'(5)) begin
                        n_height = {i_data_byte, 8'h00};
                    end else if (frame_off == INDEX_BITS'(6)) begin
                        n_height = {n_height[15:8], i_data_byte};
                    end else if (frame_off == INDEX_BITS'(7)) begin
                        n_width = {i_data_byte, 8'h00};
                    end else if (frame_off == INDEX_BITS'(8)) begin
                        n_width = {n_width[15:8], i_data_byte};
                    end else if (frame_off == INDEX_BITS'(9)) begin
                        n_comp = i_data_byte;
                        done   = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // advance the byte counter, give up when it saturates
            if (!done) begin
                if (n_index == {INDEX_BITS{1'b1}}) begin
                    n_width  = '0;
                    n_height = '0;
                    n_prec   = DEF_PRECISION;
                    n_comp   = DEF_COMPONENTS;
                    done     = 1'b1;
                end else begin
                    n_index = n_index + INDEX_BITS'(1);
                end
            end

            if (done) begin
                n_finished = 1'b1;
                n_phase    = PH_DONE;
            end
        end
    end

    // Hold the stream length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stream_length <= i_cfg_stream_length;
        end
    end

    // Advance parse state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index    <= '0;
            r_np       <= NP_W'(2);
            r_phase    <= PH_SOI0;
            r_mstart   <= '0;
            r_len_hi   <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_prec     <= DEF_PRECISION;
            r_comp     <= DEF_COMPONENTS;
            r_finished <= 1'b0;
        end else if (in_accept) begin
            r_index    <= n_index;
            r_np       <= n_np;
            r_phase    <= n_phase;
            r_mstart   <= n_mstart;
            r_len_hi   <= n_len_hi;
            r_width    <= n_width;
            r_height   <= n_height;
            r_prec     <= n_prec;
            r_comp     <= n_comp;
            r_finished <= n_finished;
        end
    end

    // Result valid: set on a deciding item, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && done) begin
            r_out_status <= (n_width == '0) || (n_height == '0);
            r_out_width  <= n_width;
            r_out_height <= n_height;
            r_out_prec   <= n_prec;
            r_out_comp   <= n_comp;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_header_status    = r_out_status;
    assign o_image_width      = r_out_width;
    assign o_image_height     = r_out_height;
    assign o_sample_precision = r_out_prec;
    assign o_component_count  = r_out_comp;

    // Checks
    assign out_dims_zero = (r_out_width == '0) || (r_out_height == '0);

    `JFHS_ASSERT_IMPL(a_finished_phase, i_clk, i_rst_n, 1'b1, r_finished == (r_phase == PH_DONE))
    `JFHS_ASSERT_IMPL(a_status_fields, i_clk, i_rst_n, o_out_valid, o_header_status == out_dims_zero)
    `JFHS_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_in_ready)
    `JFHS_ASSERT_NEXT(a_result_sets_finished, i_clk, i_rst_n, in_accept && done, r_finished && r_out_valid)

endmodule
